FILE: rtl/core/alpha_overlay_blend_10bit_unit_assert.svh
// assertion macros for the overlay blend unit
`ifndef ALPHA_OVERLAY_BLEND_10BIT_UNIT_ASSERT_SVH
`define ALPHA_OVERLAY_BLEND_10BIT_UNIT_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define AOB_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define AOB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define AOB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/aob_pkg.sv
// shared types, constants and helpers of the overlay blend unit
`default_nettype none

package aob_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_MARK_WIDTH    = 3'd2,
    REG_MARK_HEIGHT   = 3'd3,
    REG_RIGHT_MARGIN  = 3'd4,
    REG_BOTTOM_MARGIN = 3'd5
  } cfg_reg_e;

  // register reset values
  localparam logic [13:0] FRAME_WIDTH_RST   = 14'd1920;
  localparam logic [13:0] FRAME_HEIGHT_RST  = 14'd1080;
  localparam logic [10:0] MARK_WIDTH_RST    = 11'd0;
  localparam logic [10:0] MARK_HEIGHT_RST   = 11'd0;
  localparam logic [12:0] RIGHT_MARGIN_RST  = 13'd100;
  localparam logic [12:0] BOTTOM_MARGIN_RST = 13'd30;

  // arithmetic constants
  localparam logic [13:0] FRAME_MAX = 14'd8192;
  localparam logic [10:0] ONE_Q10   = 11'd1024;

  // widths
  localparam int unsigned TIDX_W  = 22;
  localparam int unsigned ENTRY_W = 43;
  localparam int unsigned PIX_W   = 32;

  // queue depths
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [13:0] frame_width;
    logic [13:0] frame_height;
    logic [10:0] mark_width;
    logic [10:0] mark_height;
    logic [12:0] right_margin;
    logic [12:0] bottom_margin;
  } cfg_t;

  // one classified item between front and back
  typedef struct packed {
    logic               is_load;
    logic               hit;
    logic               last;
    logic [TIDX_W-1:0]  addr;
    logic [ENTRY_W-1:0] data;
  } q_entry_t;

  // one result beat
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } res_t;

  // 8-bit channel to 10 bits by bit replication
  function automatic logic [9:0] widen8(input logic [7:0] c);
    return {c, c[7:6]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/aob_fifo.sv
// small register fifo used as the work queue and the result queue
`default_nettype none

module aob_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         empty_o,
  output logic                         full_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;

  // pointer advance with wrap
  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) data_q[wr_ptr_q] <= data_i;
  end

  assign data_o  = data_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign count_o = count_q;

endmodule

`default_nettype wire

FILE: rtl/core/aob_front.sv
// front part: accepts items, tracks raster position, builds store entries
`default_nettype none

module aob_front #(
  parameter int unsigned MARK_TEXELS = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aob_pkg::cfg_t     cfg_i,
  input  logic              push_i,
  output logic              full_o,
  input  logic              action_i,
  input  logic [15:0]       texel_index_i,
  input  logic [7:0]        texel_red_i,
  input  logic [7:0]        texel_green_i,
  input  logic [7:0]        texel_blue_i,
  input  logic [7:0]        texel_alpha_i,
  input  logic [31:0]       pixel_in_i,
  output logic              q_push_o,
  output aob_pkg::q_entry_t q_entry_o,
  input  logic              q_full_i
);

  import aob_pkg::*;

  localparam logic [21:0] TEXELS = 22'(MARK_TEXELS);

  // raster counters
  logic [12:0] col_q, col_d, line_q, line_d;

  // stage one registers
  logic        f1_valid_q, f1_valid_d;
  logic        f1_is_load_q, f1_hit_q, f1_last_q;
  logic [10:0] f1_dx_q, f1_dy_q;
  logic [15:0] f1_idx_q;
  logic [9:0]  f1_r_q, f1_g_q, f1_b_q, f1_a_q;
  logic [31:0] f1_pix_q;

  logic        f1_en, accept, idx_ok;
  logic [13:0] fw, fh, col_next, line_next;
  logic signed [15:0] x_s, y_s, end_x, begin_x, end_y, begin_y;
  logic [15:0] off_x, off_y;
  logic        in_win, last;

  // stage one holds while its item cannot enter the queue
  assign f1_en  = !f1_valid_q || !q_full_i;
  assign full_o = !f1_en;
  assign accept = push_i && f1_en;
  assign idx_ok = ({6'b0, texel_index_i} < TEXELS);
  assign f1_valid_d = accept && (action_i || idx_ok);

  // clamped frame size
  always_comb begin
    priority if (cfg_i.frame_width == '0)     fw = 14'd1;
    else if (cfg_i.frame_width > FRAME_MAX)   fw = FRAME_MAX;
    else                                      fw = cfg_i.frame_width;
    priority if (cfg_i.frame_height == '0)    fh = 14'd1;
    else if (cfg_i.frame_height > FRAME_MAX)  fh = FRAME_MAX;
    else                                      fh = cfg_i.frame_height;
  end

  // window bounds and position test
  assign x_s     = signed'({3'b0, col_q});
  assign y_s     = signed'({3'b0, line_q});
  assign end_x   = signed'({2'b0, fw}) - signed'({3'b0, cfg_i.right_margin});
  assign begin_x = end_x - signed'({5'b0, cfg_i.mark_width});
  assign end_y   = signed'({2'b0, fh}) - signed'({3'b0, cfg_i.bottom_margin});
  assign begin_y = end_y - signed'({5'b0, cfg_i.mark_height});
  assign in_win  = (x_s >= begin_x) && (x_s < end_x) && (y_s >= begin_y) && (y_s < end_y);
  assign off_x   = 16'(x_s - begin_x);
  assign off_y   = 16'(y_s - begin_y);
  assign last    = ({1'b0, col_q} == fw - 14'd1) && ({1'b0, line_q} == fh - 14'd1);

  // raster advance with wrap
  assign col_next  = {1'b0, col_q} + 14'd1;
  assign line_next = {1'b0, line_q} + 14'd1;
  always_comb begin
    col_d  = col_next[12:0];
    line_d = line_q;
    if (col_next >= fw) begin
      col_d  = '0;
      line_d = (line_next >= fh) ? '0 : line_next[12:0];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      col_q      <= '0;
      line_q     <= '0;
    end else begin
      if (f1_en) f1_valid_q <= f1_valid_d;
      if (accept && action_i) begin
        col_q  <= col_d;
        line_q <= line_d;
      end
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (f1_en) begin
      f1_is_load_q <= !action_i;
      f1_hit_q     <= in_win;
      f1_last_q    <= last;
      f1_dx_q      <= off_x[10:0];
      f1_dy_q      <= off_y[10:0];
      f1_idx_q     <= texel_index_i;
      f1_r_q       <= widen8(texel_red_i);
      f1_g_q       <= widen8(texel_green_i);
      f1_b_q       <= widen8(texel_blue_i);
      f1_a_q       <= widen8(texel_alpha_i);
      f1_pix_q     <= pixel_in_i;
    end
  end

  // texel index of a window pixel
  logic [21:0] row_base, tidx;
  assign row_base = 22'(f1_dy_q) * 22'(cfg_i.mark_width);
  assign tidx     = row_base + 22'(f1_dx_q);

  // premultiplied color of a loaded texel
  logic [19:0] prod_r, prod_g, prod_b;
  assign prod_r = 20'(f1_r_q) * 20'(f1_a_q);
  assign prod_g = 20'(f1_g_q) * 20'(f1_a_q);
  assign prod_b = 20'(f1_b_q) * 20'(f1_a_q);

  // queue entry
  always_comb begin
    q_entry_o.is_load = f1_is_load_q;
    q_entry_o.last    = f1_last_q;
    if (f1_is_load_q) begin
      q_entry_o.hit  = 1'b0;
      q_entry_o.addr = TIDX_W'(f1_idx_q);
      q_entry_o.data = {ONE_Q10 - {1'b0, f1_a_q}, prod_r[19:10], prod_g[19:10],
                        prod_b[19:10], 2'b00};
    end else begin
      q_entry_o.hit  = f1_hit_q && (tidx < TEXELS);
      q_entry_o.addr = tidx;
      q_entry_o.data = {11'b0, f1_pix_q};
    end
  end

  assign q_push_o = f1_valid_q && !q_full_i;

endmodule

`default_nettype wire

FILE: rtl/core/aob_back.sv
// back part: mark store access and per-channel blend
`default_nettype none

module aob_back #(
  parameter int unsigned MARK_TEXELS = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  aob_pkg::q_entry_t               q_entry_i,
  input  logic                            q_empty_i,
  output logic                            q_pop_o,
  input  logic [aob_pkg::OUT_CNT_W-1:0]   o_count_i,
  output logic                            o_push_o,
  output aob_pkg::res_t                   o_data_o
);

  import aob_pkg::*;

  localparam int unsigned AW = (MARK_TEXELS > 1) ? $clog2(MARK_TEXELS) : 1;

  // mark store: alpha complement in 42..32, premultiplied color in 31..0
  logic [ENTRY_W-1:0] mark_mem [MARK_TEXELS];
  logic [ENTRY_W-1:0] rd_q;

  logic        b1_valid_q, b1_hit_q, b1_last_q;
  logic [31:0] b1_pix_q;
  logic        b2_valid_q, b2_blend_q, b2_last_q;
  logic [31:0] b2_pix_q, b2_pm_q;
  logic [20:0] b2_prod_r_q, b2_prod_g_q, b2_prod_b_q;

  logic              issue, credit_ok;
  logic [AW-1:0]     addr;
  logic [OUT_CNT_W:0] pending;

  // results in flight must fit in the result queue
  assign pending   = (OUT_CNT_W+1)'(o_count_i) + (OUT_CNT_W+1)'(b1_valid_q)
                   + (OUT_CNT_W+1)'(b2_valid_q);
  assign credit_ok = pending < (OUT_CNT_W+1)'(OUT_DEPTH);
  assign issue     = !q_empty_i && (q_entry_i.is_load || credit_ok);
  assign q_pop_o   = issue;
  assign addr      = q_entry_i.addr[AW-1:0];

  // store write for loads, registered read for window pixels
  always_ff @(posedge clk_i) begin
    if (issue && q_entry_i.is_load) mark_mem[addr] <= q_entry_i.data;
    if (issue && !q_entry_i.is_load && q_entry_i.hit) rd_q <= mark_mem[addr];
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= issue && !q_entry_i.is_load;
      b2_valid_q <= b1_valid_q;
    end
  end

  // channel scaling by the alpha complement
  logic [10:0] inv_a;
  assign inv_a = rd_q[42:32];

  always_ff @(posedge clk_i) begin
    b1_hit_q    <= q_entry_i.hit;
    b1_last_q   <= q_entry_i.last;
    b1_pix_q    <= q_entry_i.data[31:0];
    b2_blend_q  <= b1_hit_q && (inv_a != ONE_Q10);
    b2_last_q   <= b1_last_q;
    b2_pix_q    <= b1_pix_q;
    b2_pm_q     <= rd_q[31:0];
    b2_prod_r_q <= 21'(b1_pix_q[31:22]) * 21'(inv_a);
    b2_prod_g_q <= 21'(b1_pix_q[21:12]) * 21'(inv_a);
    b2_prod_b_q <= 21'(b1_pix_q[11:2]) * 21'(inv_a);
  end

  // add premultiplied color
  logic [31:0] scaled;
  assign scaled = {b2_prod_r_q[19:10], b2_prod_g_q[19:10], b2_prod_b_q[19:10], 2'b00};

  assign o_push_o       = b2_valid_q;
  assign o_data_o.pixel = b2_blend_q ? (scaled + b2_pm_q) : b2_pix_q;
  assign o_data_o.last  = b2_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/alpha_overlay_blend_10bit_unit.sv
// top level of the overlay blend unit: registers, queues, front and back
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------
//  items    | in        | push / full        | action, texel index, rgba texel, pixel
//  results  | out       | empty / pop        | pixel out, last of frame
//  config   | in        | cfg_valid / ready  | register index, write data
//
// one item per clock while full is low; pixels pass the front register, work queue,
// store read, scale multiply and result queue to the ports; loads give no result
// reset clears raster counters and queues and loads register defaults; the mark
// store is not cleared and holds garbage until loaded
// full rises when the work queue is full and the front register is occupied
// the back issues a pixel only while the result queue has a free slot for it
`default_nettype none
`include "alpha_overlay_blend_10bit_unit_assert.svh"

module alpha_overlay_blend_10bit_unit #(
  parameter int unsigned MARK_TEXELS = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // item queue side
  input  logic                            push,
  output logic                            full,
  input  logic                            action_i,
  input  logic [15:0]                     texel_index_i,
  input  logic [7:0]                      texel_red_i,
  input  logic [7:0]                      texel_green_i,
  input  logic [7:0]                      texel_blue_i,
  input  logic [7:0]                      texel_alpha_i,
  input  logic [31:0]                     pixel_in_i,
  // result queue side
  output logic                            empty,
  input  logic                            pop,
  output logic [31:0]                     pixel_out_o,
  output logic                            last_of_frame_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [aob_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [aob_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import aob_pkg::*;

  cfg_t     cfg_q;
  q_entry_t q_in, q_head;
  res_t     o_in, o_head;
  logic     q_push, q_pop, q_empty, q_full;
  logic     o_push, o_empty, o_full;
  logic [QUEUE_CNT_W-1:0] q_count;
  logic [OUT_CNT_W-1:0]   o_count;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= FRAME_WIDTH_RST;
      cfg_q.frame_height  <= FRAME_HEIGHT_RST;
      cfg_q.mark_width    <= MARK_WIDTH_RST;
      cfg_q.mark_height   <= MARK_HEIGHT_RST;
      cfg_q.right_margin  <= RIGHT_MARGIN_RST;
      cfg_q.bottom_margin <= BOTTOM_MARGIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data_i;
        REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_data_i;
        REG_MARK_WIDTH:    cfg_q.mark_width    <= cfg_data_i[10:0];
        REG_MARK_HEIGHT:   cfg_q.mark_height   <= cfg_data_i[10:0];
        REG_RIGHT_MARGIN:  cfg_q.right_margin  <= cfg_data_i[12:0];
        REG_BOTTOM_MARGIN: cfg_q.bottom_margin <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify
  aob_front #(
    .MARK_TEXELS(MARK_TEXELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push_i        (push),
    .full_o        (full),
    .action_i      (action_i),
    .texel_index_i (texel_index_i),
    .texel_red_i   (texel_red_i),
    .texel_green_i (texel_green_i),
    .texel_blue_i  (texel_blue_i),
    .texel_alpha_i (texel_alpha_i),
    .pixel_in_i    (pixel_in_i),
    .q_push_o      (q_push),
    .q_entry_o     (q_in),
    .q_full_i      (q_full)
  );

  // work queue between front and back
  aob_fifo #(
    .WIDTH($bits(q_entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_work_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_head),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_count)
  );

  // back: store access and blend
  aob_back #(
    .MARK_TEXELS(MARK_TEXELS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_entry_i (q_head),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .o_count_i (o_count),
    .o_push_o  (o_push),
    .o_data_o  (o_in)
  );

  // result queue
  aob_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (o_push),
    .data_i  (o_in),
    .pop_i   (pop && !o_empty),
    .data_o  (o_head),
    .empty_o (o_empty),
    .full_o  (o_full),
    .count_o (o_count)
  );

  assign empty           = o_empty;
  assign pixel_out_o     = o_head.pixel;
  assign last_of_frame_o = o_head.last;

  // checks
  `AOB_ASSERT_IMP(a_work_queue_no_overflow, q_push, !q_full, "work queue written while full")
  `AOB_ASSERT_IMP(a_result_queue_no_overflow, o_push, !o_full, "result beat with no free slot")
  `AOB_ASSERT_IMP(a_full_from_queue, full, q_full, "full raised with room in work queue")
  `AOB_ASSERT_NXT(a_work_queue_grows, q_push && !q_pop, q_count == $past(q_count) + 1'b1, "work queue count lost a beat")
  `AOB_ASSERT(a_pop_needs_entry, !q_pop || !q_empty, "work queue popped while empty")

endmodule

`default_nettype wire

FILE: tb/sv/alpha_overlay_blend_10bit_unit_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the overlay blend unit: texel loads, raster blend, register changes

module alpha_overlay_blend_10bit_unit_test;
  import aob_pkg::*;

  localparam int MARK_TEXELS = 65536;
  localparam int DRAIN_SLACK = 8;
  localparam bit ACT_LOAD = 1'b0;
  localparam bit ACT_PIXEL = 1'b1;
  localparam bit [31:0] RB_MASK = 32'hFFC0_0FFC;
  localparam bit [31:0] G_MASK = 32'h003F_F000;

  typedef struct packed {
    bit [31:0] pixel;
    bit        last;
  } overlay_beat_t;

  // block ports, all inputs known from time zero
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  action_i = 1'b0;
  logic [15:0]           texel_index_i = '0;
  logic [7:0]            texel_red_i = '0;
  logic [7:0]            texel_green_i = '0;
  logic [7:0]            texel_blue_i = '0;
  logic [7:0]            texel_alpha_i = '0;
  logic [31:0]           pixel_in_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [31:0]           pixel_out_o;
  logic                  last_of_frame_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // predictor state: mark store, registers, raster position
  bit [31:0] mark_color [MARK_TEXELS];
  bit [10:0] mark_inv [MARK_TEXELS];
  bit        mark_loaded [MARK_TEXELS];
  bit [13:0] cfg_frame_w = FRAME_WIDTH_RST;
  bit [13:0] cfg_frame_h = FRAME_HEIGHT_RST;
  bit [10:0] cfg_mark_w = MARK_WIDTH_RST;
  bit [10:0] cfg_mark_h = MARK_HEIGHT_RST;
  bit [12:0] cfg_right = RIGHT_MARGIN_RST;
  bit [12:0] cfg_bottom = BOTTOM_MARGIN_RST;
  bit [12:0] col_pos = '0;
  bit [12:0] row_pos = '0;

  overlay_beat_t pending_pixels[$];
  overlay_beat_t want_beat;

  int error_count = 0;
  int accepted_items = 0;
  int load_items = 0;
  int checked_pixels = 0;
  int blended_pixels = 0;
  int frame_ends = 0;
  int settings_written = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_cycles = 0;

  alpha_overlay_blend_10bit_unit #(
    .MARK_TEXELS(MARK_TEXELS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .action_i       (action_i),
    .texel_index_i  (texel_index_i),
    .texel_red_i    (texel_red_i),
    .texel_green_i  (texel_green_i),
    .texel_blue_i   (texel_blue_i),
    .texel_alpha_i  (texel_alpha_i),
    .pixel_in_i     (pixel_in_i),
    .empty          (empty),
    .pop            (pop),
    .pixel_out_o    (pixel_out_o),
    .last_of_frame_o(last_of_frame_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("alpha_overlay_blend_10bit_unit_test: done, errors");
    $finish;
  end

  // frame size as the block uses it
  function automatic int frame_size(bit [13:0] v);
    if (v == 14'd0) return 1;
    if (v > FRAME_MAX) return int'(FRAME_MAX);
    return int'(v);
  endfunction

  // window test for the current raster position, gives the row-major texel index
  function automatic bit mark_lookup(output longint tidx);
    int x, y, end_x, begin_x, end_y, begin_y;
    x = int'(col_pos);
    y = int'(row_pos);
    end_x = frame_size(cfg_frame_w) - int'(cfg_right);
    begin_x = end_x - int'(cfg_mark_w);
    end_y = frame_size(cfg_frame_h) - int'(cfg_bottom);
    begin_y = end_y - int'(cfg_mark_h);
    tidx = longint'(y - begin_y) * longint'(cfg_mark_w) + longint'(x - begin_x);
    return (x >= begin_x) && (x < end_x) && (y >= begin_y) && (y < end_y);
  endfunction

  // widen, premultiply and keep the inverse alpha
  function automatic void store_mark_texel(bit [15:0] idx, bit [7:0] r, bit [7:0] g,
                                           bit [7:0] b, bit [7:0] a);
    bit [9:0]  a10;
    bit [19:0] pr, pg, pb;
    a10 = {a, a[7:6]};
    pr = {r, r[7:6]} * a10;
    pg = {g, g[7:6]} * a10;
    pb = {b, b[7:6]} * a10;
    mark_color[idx] = {pr[19:10], pg[19:10], pb[19:10], 2'b00};
    mark_inv[idx] = ONE_Q10 - {1'b0, a10};
    mark_loaded[idx] = 1'b1;
    load_items++;
  endfunction

  // blend one pixel, step the raster position, queue the expected beat
  function automatic void predict_pixel(bit [31:0] pix_in);
    longint    tidx;
    bit [31:0] pix;
    bit [63:0] rb, gg, mix;
    bit [10:0] inv;
    bit        last;
    int        fw, fh;
    fw = frame_size(cfg_frame_w);
    fh = frame_size(cfg_frame_h);
    pix = pix_in;
    last = (int'(col_pos) == fw - 1) && (int'(row_pos) == fh - 1);
    if (mark_lookup(tidx)) begin
      // texels past the store are see-through
      if (tidx < MARK_TEXELS) begin
        inv = mark_inv[tidx];
        if (inv != ONE_Q10) begin
          rb = 64'(pix & RB_MASK) * 64'(inv);
          gg = 64'(pix & G_MASK) * 64'(inv);
          mix = (rb & (64'(RB_MASK) << 10)) | (gg & (64'(G_MASK) << 10));
          pix = mix[41:10] + mark_color[tidx];
          blended_pixels++;
        end
      end
    end
    // counters past a shrunken frame wrap on the next step
    if (int'(col_pos) + 1 >= fw) begin
      col_pos = '0;
      if (int'(row_pos) + 1 >= fh) row_pos = '0;
      else row_pos = row_pos + 13'd1;
    end else begin
      col_pos = col_pos + 13'd1;
    end
    pending_pixels.push_back('{pixel: pix, last: last});
  endfunction

  // receiver: random pop, or a counted hold-off
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      pop = 1'b0;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else begin
      pop = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result check on each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        $error("result beat with no pixel pending: pixel_out %h", pixel_out_o);
        error_count++;
      end else begin
        want_beat = pending_pixels.pop_front();
        checked_pixels++;
        if (want_beat.last) frame_ends++;
        if (pixel_out_o !== want_beat.pixel) begin
          $error("pixel_out: expected %h, actual %h", want_beat.pixel, pixel_out_o);
          error_count++;
        end
        if (last_of_frame_o !== want_beat.last) begin
          $error("last_of_frame: expected %b, actual %b", want_beat.last, last_of_frame_o);
          error_count++;
        end
      end
    end
  end

  // one item beat; entered and left just after a falling edge
  task automatic send_item(input bit act, input bit [15:0] idx, input bit [7:0] r,
                           input bit [7:0] g, input bit [7:0] b, input bit [7:0] a,
                           input bit [31:0] pix);
    if ($urandom_range(99) < tx_idle_pct) begin
      push = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    push = 1'b1;
    action_i = act;
    texel_index_i = idx;
    texel_red_i = r;
    texel_green_i = g;
    texel_blue_i = b;
    texel_alpha_i = a;
    pixel_in_i = pix;
    do @(posedge clk_i); while (full);
    if (act == ACT_LOAD) store_mark_texel(idx, r, g, b, a);
    else predict_pixel(pix);
    accepted_items++;
    @(negedge clk_i);
  endtask

  task automatic send_load(input bit [15:0] idx, input bit [7:0] r, input bit [7:0] g,
                           input bit [7:0] b, input bit [7:0] a);
    send_item(ACT_LOAD, idx, r, g, b, a, $urandom);
  endtask

  // random texel, alpha often clear or opaque
  task automatic send_random_load(input bit [15:0] idx);
    bit [7:0] a;
    case ($urandom_range(4))
      0: a = 8'h00;
      1: a = 8'hFF;
      default: a = 8'($urandom);
    endcase
    send_load(idx, 8'($urandom), 8'($urandom), 8'($urandom), a);
  endtask

  // a pixel never reads an empty store entry: load it first
  task automatic send_pixel(input bit [31:0] pix);
    longint tidx;
    if (mark_lookup(tidx)) begin
      if (tidx < MARK_TEXELS) begin
        if (!mark_loaded[tidx]) send_random_load(16'(tidx));
      end
    end
    send_item(ACT_PIXEL, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), pix);
  endtask

  // hold the sender until every pixel has come back and the pipe is quiet
  task automatic wait_drained();
    push = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input bit [13:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_FRAME_WIDTH:   cfg_frame_w = data;
      REG_FRAME_HEIGHT:  cfg_frame_h = data;
      REG_MARK_WIDTH:    cfg_mark_w = data[10:0];
      REG_MARK_HEIGHT:   cfg_mark_h = data[10:0];
      REG_RIGHT_MARGIN:  cfg_right = data[12:0];
      REG_BOTTOM_MARGIN: cfg_bottom = data[12:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // full register set, written only with the block idle
  task automatic write_setting(input bit [13:0] fw, input bit [13:0] fh,
                               input bit [13:0] mw, input bit [13:0] mh,
                               input bit [13:0] rm, input bit [13:0] bm);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_MARK_WIDTH, mw);
    write_reg(REG_MARK_HEIGHT, mh);
    write_reg(REG_RIGHT_MARGIN, rm);
    write_reg(REG_BOTTOM_MARGIN, bm);
    cfg_valid_i = 1'b0;
    settings_written++;
  endtask

  // reset window, then clear, opaque, partial and black texels over a small frame
  task automatic test_directed_blend();
    int i;
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    write_setting(14'd4, 14'd3, 14'd2, 14'd2, 14'd1, 14'd0);
    send_load(16'd0, 8'hFF, 8'h00, 8'hFF, 8'h00);
    send_load(16'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_load(16'd2, 8'h80, 8'h40, 8'h01, 8'h80);
    send_load(16'd3, 8'h00, 8'h00, 8'h00, 8'hFF);
    for (i = 0; i < 12; i++) begin
      case (i % 4)
        0: send_pixel(32'h0000_0000);
        1: send_pixel(32'hFFFF_FFFF);
        2: send_pixel(32'h0000_0003);
        default: send_pixel(32'hFFC0_0FFC);
      endcase
    end
  endtask

  // zero and oversize frames, window far outside the store, shrink mid-frame
  task automatic test_clamp_and_wrap();
    int i;
    write_setting(14'd0, 14'd0, 14'd1, 14'd1, 14'd0, 14'd0);
    send_load(16'd0, 8'h12, 8'hED, 8'h7F, 8'hFF);
    for (i = 0; i < 3; i++) send_pixel($urandom);
    write_setting(14'd16383, 14'd16383, 14'd2047, 14'd2047, 14'd8191, 14'd8191);
    for (i = 0; i < 4; i++) send_pixel($urandom);
    write_setting(14'd3, 14'd2, 14'd3, 14'd2, 14'd0, 14'd0);
    for (i = 0; i < 8; i++) send_pixel($urandom);
  endtask

  // mostly small frames with a window on them, a few extreme settings
  task automatic pick_random_setting();
    bit [13:0] fw, fh, mw, mh, rm, bm;
    fw = 14'($urandom_range(1, 24));
    fh = 14'($urandom_range(1, 12));
    mw = 14'($urandom_range(0, int'(fw)));
    mh = 14'($urandom_range(0, int'(fh)));
    rm = 14'($urandom_range(0, 3));
    bm = 14'($urandom_range(0, 2));
    case ($urandom_range(9))
      0: begin
        fw = 14'($urandom_range(8193, 16383));
        mw = 14'($urandom_range(0, 2047));
        rm = 14'($urandom_range(0, 8191));
      end
      1: begin
        fw = 14'd0;
        fh = 14'($urandom_range(0, 3));
      end
      2: begin
        mw = 14'd2047;
        mh = 14'($urandom_range(0, 2047));
      end
      3: begin
        rm = 14'd8191;
        bm = 14'($urandom_range(0, 8191));
      end
      default: ;
    endcase
    write_setting(fw, fh, mw, mh, rm, bm);
  endtask

  // raster pixels with texel loads mixed in, mostly into the window
  task automatic test_random_stream(input int phases, input int items);
    int     p, i, top;
    longint area;
    for (p = 0; p < phases; p++) begin
      pick_random_setting();
      area = longint'(cfg_mark_w) * longint'(cfg_mark_h);
      top = (area > MARK_TEXELS) ? MARK_TEXELS - 1 : int'(area) - 1;
      for (i = 0; i < items; i++) begin
        if ($urandom_range(99) < 15) begin
          if (area > 0 && $urandom_range(99) < 70)
            send_random_load(16'($urandom_range(0, top)));
          else
            send_random_load(16'($urandom));
        end else begin
          case ($urandom_range(7))
            0: send_pixel(32'h0000_0000);
            1: send_pixel(32'hFFFF_FFFF);
            default: send_pixel($urandom);
          endcase
        end
      end
    end
  endtask

  // long receiver hold-off fills the block, then a full drain mid-stream
  task automatic test_backpressure();
    int keep_tx, i;
    keep_tx = tx_idle_pct;
    tx_idle_pct = 0;
    write_setting(14'd8, 14'd4, 14'd4, 14'd3, 14'd2, 14'd1);
    rx_hold_cycles = 200;
    for (i = 0; i < 32; i++) send_pixel($urandom);
    wait_drained();
    for (i = 0; i < 16; i++) send_pixel($urandom);
    tx_idle_pct = keep_tx;
  endtask

  // test sequence
  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    tx_idle_pct = 7;
    rx_idle_pct = 49;
    test_directed_blend();
    test_clamp_and_wrap();
    test_random_stream(4, 40);

    tx_idle_pct = 49;
    rx_idle_pct = 7;
    test_random_stream(4, 40);
    test_backpressure();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_stream(4, 40);

    push = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);

    $display("covered %0d items (%0d texel loads) over %0d register settings",
             accepted_items, load_items, settings_written);
    $display("checked %0d pixels, %0d blended, %0d frame ends",
             checked_pixels, blended_pixels, frame_ends);
    if (error_count == 0) begin
      $display("alpha_overlay_blend_10bit_unit_test: done, clean");
    end else begin
      $display("alpha_overlay_blend_10bit_unit_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/aob_pkg.sv
rtl/core/aob_fifo.sv
rtl/core/aob_front.sv
rtl/core/aob_back.sv
rtl/core/alpha_overlay_blend_10bit_unit.sv
tb/sv/alpha_overlay_blend_10bit_unit_test.sv
